/* hdl/utkp_pkg.sv */
// ----------------------------------------------------------------------------
// utkp_pkg
// Shared widths, codes and the saturating absolute value for the top-k picker.
// ----------------------------------------------------------------------------
`default_nettype none

package utkp_pkg;

    localparam int KIND_W  = 2;
    localparam int SCORE_W = 32;
    localparam int ID_W    = 12;
    localparam int PICK_W  = 5;
    localparam int OBJ_W   = 13;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [KIND_W-1:0] KIND_SCORE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    localparam logic REG_PICK_COUNT   = 1'b0;
    localparam logic REG_OBJECT_COUNT = 1'b1;

    localparam logic [PICK_W-1:0] PICK_RESET = 5'd1;
    localparam logic [OBJ_W-1:0]  OBJ_RESET  = 13'd4096;

    localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;

    // |s| with the most negative value clipped to the largest positive one
    function automatic logic [SCORE_W-1:0] sat_abs(input logic [SCORE_W-1:0] s);
        logic [SCORE_W-1:0] r;
        if (s == SCORE_MIN) begin
            r = SCORE_MAX;
        end else if (s[SCORE_W-1]) begin
            r = (~s) + 32'd1;
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/utkp_item_if.sv */
// ----------------------------------------------------------------------------
// utkp_item_if
// Input channel: score, remove and restart beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface utkp_item_if;
    import utkp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [SCORE_W-1:0] score_value;
    logic [ID_W-1:0]           remove_id;
    logic                      batch_end;

    modport source (output valid, kind, score_value, remove_id, batch_end, input ready);
    modport sink   (input valid, kind, score_value, remove_id, batch_end, output ready);
endinterface

`default_nettype wire

/* hdl/utkp_pick_if.sv */
// ----------------------------------------------------------------------------
// utkp_pick_if
// Output channel: one beat per picked object.
// ----------------------------------------------------------------------------
`default_nettype none

interface utkp_pick_if;
    import utkp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ID_W-1:0]           picked_id;
    logic signed [SCORE_W-1:0] picked_score;
    logic                      last_pick;

    modport source (output valid, picked_id, picked_score, last_pick, input ready);
    modport sink   (input valid, picked_id, picked_score, last_pick, output ready);
endinterface

`default_nettype wire

/* hdl/utkp_cfg.sv */
// ----------------------------------------------------------------------------
// utkp_cfg
// APB register file holding pick_count and object_count.
// ----------------------------------------------------------------------------
`default_nettype none

module utkp_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [utkp_pkg::ADDR_W-1:0]   paddr,
    input  wire [utkp_pkg::DATA_W-1:0]   pwdata,
    output logic [utkp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [utkp_pkg::PICK_W-1:0]  o_pick_count,
    output logic [utkp_pkg::OBJ_W-1:0]   o_object_count
);
    import utkp_pkg::*;

    logic [PICK_W-1:0] r_pick_count;
    logic [OBJ_W-1:0]  r_object_count;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_count   <= PICK_RESET;
            r_object_count <= OBJ_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_PICK_COUNT:   r_pick_count   <= pwdata[PICK_W-1:0];
                REG_OBJECT_COUNT: r_object_count <= pwdata[OBJ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PICK_COUNT:   prdata = DATA_W'(r_pick_count);
            REG_OBJECT_COUNT: prdata = DATA_W'(r_object_count);
            default:          prdata = '0;
        endcase
    end

    assign o_pick_count   = r_pick_count;
    assign o_object_count = r_object_count;
endmodule

`default_nettype wire

/* hdl/utkp_cand.sv */
// ----------------------------------------------------------------------------
// utkp_cand
// Sorted candidate list with one read port and the shared magnitude compare.
// ----------------------------------------------------------------------------
`default_nettype none

module utkp_cand #(
    parameter int MAX_PICKS = 16,
    parameter int PW        = 12
) (
    input  wire                                i_clk,
    input  wire [((MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1)-1:0] i_rd_idx,
    input  wire [utkp_pkg::SCORE_W-1:0]        i_key,
    input  wire                                i_wr_en,
    input  wire [((MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1)-1:0] i_wr_idx,
    input  wire [utkp_pkg::SCORE_W-1:0]        i_wr_score,
    input  wire [PW-1:0]                       i_wr_pos,
    output logic [utkp_pkg::SCORE_W-1:0]       o_rd_score,
    output logic [PW-1:0]                      o_rd_pos,
    output logic                               o_less
);
    import utkp_pkg::*;

    logic [SCORE_W-1:0] r_score [MAX_PICKS];
    logic [PW-1:0]      r_pos   [MAX_PICKS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_score[i_wr_idx] <= i_wr_score;
            r_pos[i_wr_idx]   <= i_wr_pos;
        end
    end

    assign o_rd_score = r_score[i_rd_idx];
    assign o_rd_pos   = r_pos[i_rd_idx];
    assign o_less     = i_key < sat_abs(o_rd_score);
endmodule

`default_nettype wire

/* hdl/uncertainty_top_k_picker.sv */
// ----------------------------------------------------------------------------
// uncertainty_top_k_picker
// Keeps an id pool and picks the smallest-magnitude scores of each batch.
// Score beat: accepted in idle, then insert steps that shift the candidate list down.
// Batch close: a start step, then read, load and hold states per pick beat, then
// removal scans and drops, one per pick emitted; bound by the single candidate read port.
// Remove beat: accepted in idle, then a scan of the live pool (one pool read a cycle),
// then drop read and write states to drop a match.
// Reset and restart: a pool rebuild pass over all MAX_OBJECTS entries, input held.
// ----------------------------------------------------------------------------
`default_nettype none

module uncertainty_top_k_picker #(
    parameter int MAX_OBJECTS = 4096,
    parameter int MAX_PICKS   = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    utkp_item_if.sink                    i_item,
    utkp_pick_if.source                  o_pick,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [utkp_pkg::ADDR_W-1:0]   paddr,
    input  wire [utkp_pkg::DATA_W-1:0]   pwdata,
    output logic [utkp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import utkp_pkg::*;

    localparam int PW = $clog2(MAX_OBJECTS);
    localparam int LW = $clog2(MAX_OBJECTS + 1);
    localparam int KW = $clog2(MAX_PICKS + 1);
    localparam int IW = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;

    typedef enum logic [10:0] {
        S_SWEEP     = 11'b000_0000_0001,
        S_IDLE      = 11'b000_0000_0010,
        S_INSERT    = 11'b000_0000_0100,
        S_EMIT_GO   = 11'b000_0000_1000,
        S_EMIT_RD   = 11'b000_0001_0000,
        S_EMIT_LD   = 11'b000_0010_0000,
        S_EMIT_HOLD = 11'b000_0100_0000,
        S_DROP_SCAN = 11'b000_1000_0000,
        S_DROP_RD   = 11'b001_0000_0000,
        S_DROP_WR   = 11'b010_0000_0000,
        S_REM_SCAN  = 11'b100_0000_0000
    } t_state;

    t_state             r_state;
    logic [LW-1:0]      r_live;
    logic [LW-1:0]      r_bpos;
    logic [KW-1:0]      r_filled;
    logic [LW-1:0]      r_cnt;
    logic               r_pend;
    logic [PW-1:0]      r_cmp_pos;
    logic [ID_W-1:0]    r_rid;
    logic [SCORE_W-1:0] r_key;
    logic [SCORE_W-1:0] r_score;
    logic [PW-1:0]      r_posn;
    logic               r_full;
    logic [KW-1:0]      r_nk;
    logic               r_last;
    logic [KW-1:0]      r_j;
    logic [KW-1:0]      r_i;
    logic [KW-1:0]      r_n;
    logic               r_found;
    logic [PW-1:0]      r_cur;
    logic               r_have_thr;
    logic [PW-1:0]      r_thr;
    logic [PW-1:0]      r_pos;
    logic               r_batch;
    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_id;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_last;
    logic [PW-1:0]      r_pool [MAX_OBJECTS];
    logic [PW-1:0]      r_rd_data;

    logic [PICK_W-1:0]  w_pick_count;
    logic [OBJ_W-1:0]   w_object_count;
    logic [KW-1:0]      w_k;
    logic [KW-1:0]      w_nk;
    logic [LW-1:0]      w_live_init;
    logic               w_acc;
    logic [KW-1:0]      w_jm1;
    logic [IW-1:0]      w_cidx;
    logic [SCORE_W-1:0] w_cscore;
    logic [PW-1:0]      w_cpos;
    logic               w_less;
    logic               w_cond;
    logic               w_keep;
    logic               w_cwe;
    logic [SCORE_W-1:0] w_cw_score;
    logic [PW-1:0]      w_cw_pos;
    logic               w_take;
    logic               w_fnd;
    logic [PW-1:0]      w_best;
    logic               w_issue;
    logic               w_match;
    logic               w_mem_we;
    logic [PW-1:0]      w_mem_waddr;
    logic [PW-1:0]      w_mem_wdata;
    logic               w_mem_re;
    logic [PW-1:0]      w_mem_raddr;
    logic [LW-1:0]      w_live_m1;
    logic [31:0]        w_rd_wide;

    utkp_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_pick_count   (w_pick_count),
        .o_object_count (w_object_count)
    );

    utkp_cand #(
        .MAX_PICKS (MAX_PICKS),
        .PW        (PW)
    ) u_cand (
        .i_clk      (i_clk),
        .i_rd_idx   (w_cidx),
        .i_key      (r_key),
        .i_wr_en    (w_cwe),
        .i_wr_idx   (r_j[IW-1:0]),
        .i_wr_score (w_cw_score),
        .i_wr_pos   (w_cw_pos),
        .o_rd_score (w_cscore),
        .o_rd_pos   (w_cpos),
        .o_less     (w_less)
    );

    always_comb begin
        if (w_pick_count == '0) begin
            w_k = KW'(1);
        end else if (32'(w_pick_count) > MAX_PICKS) begin
            w_k = KW'(MAX_PICKS);
        end else begin
            w_k = KW'(w_pick_count);
        end
        if (32'(w_object_count) > MAX_OBJECTS) begin
            w_live_init = LW'(MAX_OBJECTS);
        end else begin
            w_live_init = LW'(w_object_count);
        end
    end

    assign w_nk      = (r_filled < w_k) ? r_filled : w_k;
    assign w_acc     = i_item.valid & i_item.ready;
    assign w_jm1     = r_j - KW'(1);
    assign w_cidx    = (r_state == S_INSERT) ? w_jm1[IW-1:0] : r_i[IW-1:0];
    assign w_live_m1 = r_live - LW'(1);
    assign w_rd_wide = 32'(r_rd_data);

    // insertion step
    assign w_cond     = (r_j != '0) && w_less;
    assign w_keep     = !(r_full && (r_j == r_nk));
    assign w_cwe      = (r_state == S_INSERT) && w_keep;
    assign w_cw_score = w_cond ? w_cscore : r_score;
    assign w_cw_pos   = w_cond ? w_cpos : r_posn;

    // descending position search below the last removed one
    assign w_take = (!r_have_thr || (w_cpos < r_thr)) && (!r_found || (w_cpos > r_cur));
    assign w_fnd  = r_found || w_take;
    assign w_best = w_take ? w_cpos : r_cur;

    // id search
    assign w_issue = r_cnt < r_live;
    assign w_match = r_pend && (w_rd_wide == 32'(r_rid));

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_pos;
        w_mem_wdata = r_rd_data;
        w_mem_re    = 1'b0;
        w_mem_raddr = w_cpos;
        case (r_state)
            S_SWEEP: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_cnt[PW-1:0];
                w_mem_wdata = r_cnt[PW-1:0];
            end
            S_EMIT_RD: begin
                w_mem_re = 1'b1;
            end
            S_DROP_RD: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = w_live_m1[PW-1:0];
            end
            S_DROP_WR: begin
                w_mem_we = 1'b1;
            end
            S_REM_SCAN: begin
                w_mem_re    = w_issue && !w_match;
                w_mem_raddr = r_cnt[PW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_pool[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_pool[w_mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_cnt       <= '0;
            r_live      <= '0;
            r_bpos      <= '0;
            r_filled    <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_have_thr  <= 1'b0;
            r_batch     <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
        end else begin
            case (r_state)
                S_SWEEP: begin
                    if (r_cnt == LW'(MAX_OBJECTS - 1)) begin
                        r_live   <= w_live_init;
                        r_bpos   <= '0;
                        r_filled <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + LW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_item.kind)
                            KIND_SCORE: begin
                                if (r_bpos < r_live) begin
                                    r_key   <= sat_abs(i_item.score_value);
                                    r_score <= i_item.score_value;
                                    r_posn  <= r_bpos[PW-1:0];
                                    r_bpos  <= r_bpos + LW'(1);
                                    r_nk    <= w_nk;
                                    r_full  <= (w_nk == w_k);
                                    r_j     <= w_nk;
                                    r_last  <= i_item.batch_end;
                                    r_state <= S_INSERT;
                                end else if (i_item.batch_end) begin
                                    r_state <= S_EMIT_GO;
                                end
                            end
                            KIND_REMOVE: begin
                                r_bpos   <= '0;
                                r_filled <= '0;
                                r_rid    <= i_item.remove_id;
                                r_cnt    <= '0;
                                r_pend   <= 1'b0;
                                r_state  <= S_REM_SCAN;
                            end
                            KIND_RESTART: begin
                                r_cnt   <= '0;
                                r_state <= S_SWEEP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_INSERT: begin
                    if (w_cond) begin
                        r_j <= w_jm1;
                    end else begin
                        if (w_keep) begin
                            r_filled <= r_full ? r_nk : r_nk + KW'(1);
                        end
                        r_state <= r_last ? S_EMIT_GO : S_IDLE;
                    end
                end
                S_EMIT_GO: begin
                    r_i <= '0;
                    r_n <= w_nk;
                    if (w_nk == '0) begin
                        r_bpos   <= '0;
                        r_filled <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    r_out_id    <= w_rd_wide[ID_W-1:0];
                    r_out_score <= w_cscore;
                    r_out_last  <= (r_i == r_n - KW'(1));
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT_HOLD;
                end
                S_EMIT_HOLD: begin
                    if (o_pick.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_i        <= '0;
                            r_found    <= 1'b0;
                            r_have_thr <= 1'b0;
                            r_batch    <= 1'b1;
                            r_state    <= S_DROP_SCAN;
                        end else begin
                            r_i     <= r_i + KW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_DROP_SCAN: begin
                    if (r_i == r_n - KW'(1)) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                        if (w_fnd) begin
                            r_pos   <= w_best;
                            r_state <= S_DROP_RD;
                        end else begin
                            r_bpos   <= '0;
                            r_filled <= '0;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_found <= w_fnd;
                        r_cur   <= w_best;
                        r_i     <= r_i + KW'(1);
                    end
                end
                S_DROP_RD: begin
                    r_state <= S_DROP_WR;
                end
                S_DROP_WR: begin
                    r_live <= w_live_m1;
                    if (r_batch) begin
                        r_thr      <= r_pos;
                        r_have_thr <= 1'b1;
                        r_state    <= S_DROP_SCAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_REM_SCAN: begin
                    if (w_match) begin
                        r_pos   <= r_cmp_pos;
                        r_batch <= 1'b0;
                        r_pend  <= 1'b0;
                        r_state <= S_DROP_RD;
                    end else if (w_issue) begin
                        r_cmp_pos <= r_cnt[PW-1:0];
                        r_pend    <= 1'b1;
                        r_cnt     <= r_cnt + LW'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_pick.valid        = r_out_valid;
    assign o_pick.picked_id    = r_out_id;
    assign o_pick.picked_score = r_out_score;
    assign o_pick.last_pick    = r_out_last;

    a_idle_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> !r_out_valid)
        else $error("pick beat pending while idle");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LW'(MAX_OBJECTS))
        else $error("live count above pool size");

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= KW'(MAX_PICKS))
        else $error("candidate fill above list size");

    a_batch_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> (r_bpos <= r_live))
        else $error("batch position beyond live count");

    a_drop_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROP_WR) |-> (LW'(r_pos) < r_live))
        else $error("dropped position outside live pool");

endmodule

`default_nettype wire

/* test/utkp_pick_check.sv */
// ----------------------------------------------------------------------------
// utkp_pick_check
// Watches the item, pick and register ports of the top-k picker. It keeps its
// own copy of the id pool and the candidate list, works out the pick beats
// that each accepted item beat causes, and compares every accepted pick beat
// field by field with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module utkp_pick_check #(
    parameter int MAX_OBJECTS = 4096,
    parameter int MAX_PICKS   = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    utkp_item_if                        i_item,
    utkp_pick_if                        i_pick,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire                         pready,
    input  wire [utkp_pkg::ADDR_W-1:0]  paddr,
    input  wire [utkp_pkg::DATA_W-1:0]  pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import utkp_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic               last;
    } t_pick_beat;

    t_pick_beat          picks_due [$];
    logic [PICK_W-1:0]   pick_count_q;
    logic [OBJ_W-1:0]    object_count_q;
    logic [ID_W-1:0]     id_pool [MAX_OBJECTS];
    int unsigned         live_n;
    int unsigned         batch_pos;
    int unsigned         kept_n;
    logic [SCORE_W-1:0]  kept_score [MAX_PICKS];
    int unsigned         kept_pos [MAX_PICKS];

    function automatic logic [SCORE_W-1:0] magnitude(input logic [SCORE_W-1:0] s);
        if (s == SCORE_MIN) begin
            return SCORE_MAX;
        end
        return s[SCORE_W-1] ? -s : s;
    endfunction

    task automatic refill_pool();
        int i;
        for (i = 0; i < MAX_OBJECTS; i++) begin
            id_pool[i] = ID_W'(i);
        end
        live_n = 32'(object_count_q);
        if (live_n > MAX_OBJECTS) begin
            live_n = MAX_OBJECTS;
        end
        batch_pos = 0;
        kept_n    = 0;
    endtask

    task automatic drop_at(input int unsigned pos);
        if (live_n == 0 || pos >= live_n) begin
            return;
        end
        live_n--;
        id_pool[pos] = id_pool[live_n];
    endtask

    task automatic take_item(input logic [KIND_W-1:0] kind, input logic [SCORE_W-1:0] s,
                             input logic [ID_W-1:0] rid, input logic last);
        int unsigned        k;
        int unsigned        n;
        int unsigned        slot;
        int unsigned        i;
        int unsigned        j;
        int unsigned        tmp;
        int unsigned        order [MAX_PICKS];
        logic [SCORE_W-1:0] mag;
        logic               keep;
        t_pick_beat         beat;

        k = 32'(pick_count_q);
        if (k < 1) begin
            k = 1;
        end
        if (k > MAX_PICKS) begin
            k = MAX_PICKS;
        end
        case (kind)
            KIND_SCORE: begin
                if (batch_pos < live_n) begin
                    n    = (kept_n < k) ? kept_n : k;
                    mag  = magnitude(s);
                    keep = 1'b1;
                    slot = n;
                    if (n >= k) begin
                        if (mag < magnitude(kept_score[n-1])) begin
                            slot = n - 1;
                        end else begin
                            keep = 1'b0;
                        end
                    end
                    if (keep) begin
                        // equal magnitude never passes an earlier entry
                        while (slot > 0 && mag < magnitude(kept_score[slot-1])) begin
                            kept_score[slot] = kept_score[slot-1];
                            kept_pos[slot]   = kept_pos[slot-1];
                            slot--;
                        end
                        kept_score[slot] = s;
                        kept_pos[slot]   = batch_pos;
                        kept_n           = (n < k) ? n + 1 : n;
                    end
                    batch_pos++;
                end
                if (last) begin
                    n = (kept_n < k) ? kept_n : k;
                    for (i = 0; i < n; i++) begin
                        beat.id    = id_pool[kept_pos[i]];
                        beat.score = kept_score[i];
                        beat.last  = (i + 1 == n);
                        picks_due  = {picks_due, beat};
                        order[i] = kept_pos[i];
                    end
                    // remove from the highest position down
                    for (i = 1; i < n; i++) begin
                        tmp = order[i];
                        j   = i;
                        while (j > 0 && order[j-1] < tmp) begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = tmp;
                    end
                    for (i = 0; i < n; i++) begin
                        drop_at(order[i]);
                    end
                    batch_pos = 0;
                    kept_n    = 0;
                end
            end
            KIND_REMOVE: begin
                batch_pos = 0;
                kept_n    = 0;
                for (i = 0; i < live_n; i++) begin
                    if (id_pool[i] == rid) begin
                        drop_at(i);
                        break;
                    end
                end
            end
            KIND_RESTART: begin
                refill_pool();
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_pick_beat due;
        if (!i_rst_n) begin
            pick_count_q   = PICK_RESET;
            object_count_q = OBJ_RESET;
            refill_pool();
            picks_due.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_pick.valid && i_pick.ready) begin
                if (picks_due.size() == 0) begin
                    $error("pick beat with none due: id %0d score %08h last %0b",
                           i_pick.picked_id, i_pick.picked_score, i_pick.last_pick);
                    o_fail_count++;
                end else begin
                    due = picks_due.pop_front();
                    if (i_pick.picked_id !== due.id) begin
                        $error("picked_id: expected %0d, actual %0d", due.id, i_pick.picked_id);
                        o_fail_count++;
                    end
                    if (i_pick.picked_score !== due.score) begin
                        $error("picked_score: expected %08h, actual %08h",
                               due.score, i_pick.picked_score);
                        o_fail_count++;
                    end
                    if (i_pick.last_pick !== due.last) begin
                        $error("last_pick: expected %0b, actual %0b", due.last, i_pick.last_pick);
                        o_fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_PICK_COUNT) begin
                    pick_count_q = pwdata[PICK_W-1:0];
                end else begin
                    object_count_q = pwdata[OBJ_W-1:0];
                end
            end
            if (i_item.valid && i_item.ready) begin
                take_item(i_item.kind, i_item.score_value, i_item.remove_id, i_item.batch_end);
            end
            o_pending = picks_due.size();
        end
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the top-k picker: a directed run over score extremes, ties, removal
// of absent ids, interrupted batches, empty and over-long batches and
// out-of-range register values, then random phases of well-formed batches
// mixed with removes and restarts under random back-pressure. The pick check
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import utkp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4400;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [ADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    wire  [DATA_W-1:0]  prdata;
    wire                pready;
    int                 fail_count;
    int                 pending;
    int                 stall_cycles = 0;
    int                 hold_reqs    = 0;
    bit                 calm         = 1'b0;

    utkp_item_if item_ch ();
    utkp_pick_if pick_ch ();

    uncertainty_top_k_picker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_pick  (pick_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    utkp_pick_check u_pick_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_pick       (pick_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else if ((item_ch.valid && item_ch.ready) || (pick_ch.valid && pick_ch.ready)
                     || (!item_ch.valid && pending == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin : pick_sink
        int hold_left;
        int hold_seen;
        hold_left     = 0;
        hold_seen     = 0;
        pick_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pick_ch.ready <= 1'b0;
            end else begin
                pick_ch.ready <= calm || ($urandom_range(99) >= 8);
            end
        end
    end

    function automatic logic [SCORE_W-1:0] random_score();
        logic [SCORE_W-1:0] mag;
        mag = SCORE_W'($urandom_range(3)) << 16;
        case ($urandom_range(9))
            0: return SCORE_MIN;
            1: return SCORE_MAX;
            2, 3: return SCORE_W'($urandom_range(8)) - SCORE_W'(4);
            4: return $urandom_range(1) ? -mag : mag;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ID_W-1:0] random_id(input int span);
        if (span > 0 && $urandom_range(99) < 80) begin
            return ID_W'($urandom_range(span - 1));
        end
        return ID_W'($urandom());
    endfunction

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [SCORE_W-1:0] score,
                             input logic [ID_W-1:0] rid, input logic last);
        if (!calm && $urandom_range(99) < 8) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.score_value <= score;
        item_ch.remove_id   <= rid;
        item_ch.batch_end   <= last;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_score(input logic [SCORE_W-1:0] score, input logic last);
        send_beat(KIND_SCORE, score, ID_W'($urandom()), last);
    endtask

    task automatic send_restart();
        send_beat(KIND_RESTART, $urandom(), ID_W'($urandom()), 1'($urandom()));
    endtask

    task automatic write_reg(input logic index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    task automatic settle_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_phase(input logic [DATA_W-1:0] picks, input logic [DATA_W-1:0] objects,
                                input int beats, input int remove_pct, input int max_batch);
        int sent;
        int len;
        int roll;
        int span;
        int j;
        settle_idle();
        write_reg(REG_PICK_COUNT, picks);
        write_reg(REG_OBJECT_COUNT, objects);
        span = (objects > 4096) ? 4096 : int'(objects);
        send_restart();
        sent = 1;
        while (sent < beats) begin
            roll = int'($urandom_range(99));
            if (roll < remove_pct) begin
                send_beat(KIND_REMOVE, $urandom(), random_id(span), 1'($urandom()));
                sent++;
            end else if (roll < remove_pct + 3) begin
                send_restart();
                sent++;
            end else if (roll < remove_pct + 5) begin
                send_beat(KIND_UNUSED, $urandom(), ID_W'($urandom()), 1'($urandom()));
            end else if (roll < remove_pct + 7) begin
                wait_drained();
            end else begin
                len = int'($urandom_range(1, max_batch));
                for (j = 0; j < len; j++) begin
                    send_score(random_score(), j == len - 1);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        item_ch.valid       = 1'b0;
        item_ch.kind        = KIND_SCORE;
        item_ch.score_value = '0;
        item_ch.remove_id   = '0;
        item_ch.batch_end   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle_idle();

        // ties at full scale, both signs of one
        write_reg(REG_PICK_COUNT, 32'd4);
        send_score(SCORE_MIN, 1'b0);
        send_score(SCORE_MAX, 1'b0);
        send_score(32'hFFFF_FFFF, 1'b0);
        send_score(32'd1, 1'b0);
        send_score(32'h0001_0000, 1'b1);
        send_beat(KIND_REMOVE, $urandom(), ID_W'(3), 1'b1);
        send_beat(KIND_REMOVE, $urandom(), ID_W'(4095), 1'b0);
        send_beat(KIND_REMOVE, $urandom(), ID_W'(0), 1'b1);
        send_beat(KIND_UNUSED, $urandom(), ID_W'($urandom()), 1'b1);
        // drop a partial batch by remove, then by restart
        send_score(32'd5, 1'b0);
        send_score(32'd6, 1'b0);
        send_beat(KIND_REMOVE, $urandom(), ID_W'(10), 1'b0);
        send_score(32'd7, 1'b1);
        send_score(32'd9, 1'b0);
        send_restart();
        send_score(-32'sd9, 1'b1);

        settle_idle();
        write_reg(REG_PICK_COUNT, 32'd0);
        write_reg(REG_OBJECT_COUNT, 32'd3);
        send_restart();
        send_score(32'd100, 1'b0);
        send_score(32'd50, 1'b0);
        send_score(32'd75, 1'b0);
        send_score(32'd1, 1'b0);
        send_score(32'd2, 1'b1);

        settle_idle();
        write_reg(REG_PICK_COUNT, 32'd31);
        write_reg(REG_OBJECT_COUNT, 32'd0);
        send_restart();
        send_score(32'd0, 1'b1);

        // shrink the pick count with a batch open
        settle_idle();
        write_reg(REG_PICK_COUNT, 32'd8);
        write_reg(REG_OBJECT_COUNT, 32'd8191);
        send_restart();
        send_score(32'd3, 1'b0);
        send_score(-32'sd3, 1'b0);
        send_score(32'd3, 1'b0);
        send_score(32'd0, 1'b0);
        send_score(-32'sd2, 1'b0);
        settle_idle();
        write_reg(REG_PICK_COUNT, 32'd2);
        // hold the pick side while more beats queue up behind the close
        hold_reqs++;
        send_score(32'd1, 1'b1);
        send_score(32'd4, 1'b0);
        send_score(-32'sd4, 1'b1);

        random_phase(32'd16, 32'd40, 30, 10, 24);
        random_phase(32'd1, 32'd4096, 20, 4, 6);
        calm = 1'b1;
        random_phase(32'd5, 32'd12, 35, 10, 8);
        calm = 1'b0;
        random_phase(32'd3, 32'd200, 30, 8, 30);
        random_phase(32'd16, 32'd17, 30, 5, 20);
        random_phase(DATA_W'($urandom_range(1, 16)), DATA_W'($urandom_range(1, 64)), 30, 8, 16);

        settle_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
